[rtl/core/gmf_pkg.sv]
// gmf_pkg: types, codes and the message image builder for the gPTP framer.
// Used by every module under rtl/core.
`timescale 1ns / 1ps
package gmf_pkg;

  typedef enum logic [1:0] {OP_SYNC = 2'd0, OP_ANN = 2'd1, OP_RX = 2'd2, OP_RSVD = 2'd3} op_t;

  typedef enum logic [1:0] {K_SYNC, K_ANN, K_DRESP} item_kind_t;

  typedef enum logic [1:0] {M_SYNC, M_FU, M_ANN, M_DR} msg_kind_t;

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_FIX, B_EMIT} back_state_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam logic [31:0] NS_PER_S = 32'd1_000_000_000;
  // 2^32 = 4 * 1e9 + 144027 * 2^11
  localparam logic [17:0] FOLD_MUL = 18'd144027;

  typedef struct packed {
    item_kind_t   kind;
    logic [15:0]  seq;
    logic [63:0]  time_ns;
    logic [79:0]  port_id;
  } q_entry_t;

  function automatic logic [6:0] msg_len(msg_kind_t m);
    case (m)
      M_SYNC:  msg_len = 7'd44;
      M_FU:    msg_len = 7'd76;
      M_ANN:   msg_len = 7'd76;
      M_DR:    msg_len = 7'd54;
      default: msg_len = 7'd44;
    endcase
  endfunction

  function automatic logic [3:0] msg_code(msg_kind_t m);
    case (m)
      M_SYNC:  msg_code = 4'd0;
      M_FU:    msg_code = 4'd8;
      M_ANN:   msg_code = 4'd11;
      M_DR:    msg_code = 4'd9;
      default: msg_code = 4'd0;
    endcase
  endfunction

  // Whole message image, byte 0 in the top bits, zero past the length.
  function automatic logic [639:0] build_msg(msg_kind_t m, logic [63:0] cid,
                                             logic [15:0] seq, logic [47:0] sec,
                                             logic [31:0] nsec, logic [79:0] pid);
    logic [7:0]   p [80];
    logic [639:0] r;
    logic [15:0]  flags;
    logic [7:0]   ctl;
    logic [7:0]   ivl;
    logic [6:0]   len;
    for (int i = 0; i < 80; i++) p[i] = 8'h00;
    len = msg_len(m);
    case (m)
      M_SYNC:  begin flags = 16'h0608; ctl = 8'd0; ivl = 8'hfd; end
      M_FU:    begin flags = 16'h0408; ctl = 8'd2; ivl = 8'hfd; end
      M_ANN:   begin flags = 16'h0408; ctl = 8'd5; ivl = 8'h00; end
      default: begin flags = 16'h0408; ctl = 8'd3; ivl = 8'h7f; end
    endcase
    p[0] = {4'h1, msg_code(m)};
    p[1] = 8'h02;
    p[3] = {1'b0, len};
    p[6] = flags[15:8];
    p[7] = flags[7:0];
    for (int i = 0; i < 8; i++) p[20 + i] = cid[63 - 8 * i -: 8];
    p[28] = 8'h80;
    p[29] = 8'h01;
    p[30] = seq[15:8];
    p[31] = seq[7:0];
    p[32] = ctl;
    p[33] = ivl;
    if (m != M_SYNC) begin
      for (int i = 0; i < 6; i++) p[34 + i] = sec[47 - 8 * i -: 8];
      for (int i = 0; i < 4; i++) p[40 + i] = nsec[31 - 8 * i -: 8];
    end
    case (m)
      M_FU: begin
        p[45] = 8'd3;
        p[47] = 8'd28;
        p[49] = 8'h80;
        p[50] = 8'hc2;
        p[53] = 8'h01;
      end
      M_ANN: begin
        p[45] = 8'd37;
        p[47] = 8'd128;
        p[48] = 8'd6;
        p[49] = 8'h21;
        p[50] = 8'h43;
        p[51] = 8'h6a;
        p[52] = 8'd128;
        for (int i = 0; i < 8; i++) p[53 + i] = cid[63 - 8 * i -: 8];
        p[63] = 8'h20;
        p[65] = 8'd8;
        p[67] = 8'd8;
        for (int i = 0; i < 8; i++) p[68 + i] = cid[63 - 8 * i -: 8];
      end
      M_DR: begin
        for (int i = 0; i < 10; i++) p[44 + i] = pid[79 - 8 * i -: 8];
      end
      default: ;
    endcase
    r = '0;
    for (int i = 0; i < 80; i++) r = {r[631:0], p[i]};
    return r;
  endfunction

endpackage

[rtl/core/gptp_master_message_framer.sv]
// gptp_master_message_framer: top level of the gPTP grandmaster message builder.
// Depends on gmf_pkg, gmf_front, gmf_queue, gmf_back.
//
// Input side is a queue: present op/time_ns/rx_byte/rx_end with push; a beat
// is taken when push is high and full is low. Received datagram bytes are
// taken one per cycle while full is low. Ticks and accepted Delay_Req endings go
// into a four-entry work queue; full is high while that queue is full.
// Output side is a queue: while empty is low the oldest word is on the
// result ports; pop takes it. Words leave at one per cycle when popped.
// Each work item leaves the work queue, then the timestamp is split into
// seconds/nanoseconds (1 to 11 folding steps of the top word, then up to
// four subtracts of 1e9 and a final check), then the words go out in order:
// Sync then FU 6+10 words, Announce 10, Delay_Resp 7.
// With the back end idle, a beat reaches the first word through the work
// queue, the folding and checking states and the output word register.
// A stalled receiver holds the output word; the back end waits and the work
// queue fills, after which full stops input. The user writes clock_identity
// with cfg_we only while the block is idle; the block does not enforce it.
// Reset (rst, synchronous) clears sequences, receive state and both queues.
`timescale 1ns / 1ps
module gptp_master_message_framer
  import gmf_pkg::*;
#(
  parameter int RX_BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] clock_identity,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [63:0] time_ns,
  input  logic [7:0]  rx_byte,
  input  logic        rx_end,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] word_data,
  output logic [3:0]  word_bytes,
  output logic        packet_end,
  output logic [3:0]  msg_type,
  output logic        event_channel,
  output logic        run_last
);

  logic [63:0] clk_id;
  logic        accept;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  q_entry_t    q_wdata;
  q_entry_t    q_rdata;

  always_ff @(posedge clk) begin
    if (rst) clk_id <= '0;
    else if (cfg_we) clk_id <= clock_identity;
  end

  assign accept = push && !full;

  gmf_front #(.RX_BUFFER_BYTES(RX_BUFFER_BYTES)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .op(op), .time_ns(time_ns),
    .rx_byte(rx_byte), .rx_end(rx_end), .q_push(q_push), .q_data(q_wdata)
  );

  gmf_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .full(full),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  gmf_back u_back (
    .clk(clk), .rst(rst), .clock_identity(clk_id), .q_empty(q_empty),
    .q_data(q_rdata), .q_pop(q_pop), .word_data(word_data),
    .word_bytes(word_bytes), .packet_end(packet_end), .msg_type(msg_type),
    .event_channel(event_channel), .run_last(run_last), .empty(empty), .pop(pop)
  );

endmodule

[rtl/core/gmf_front.sv]
// gmf_front: accepts input beats, collects received datagrams, hands work items on.
// Depends on gmf_pkg.
`timescale 1ns / 1ps
module gmf_front
  import gmf_pkg::*;
#(
  parameter int RX_BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  op,
  input  logic [63:0] time_ns,
  input  logic [7:0]  rx_byte,
  input  logic        rx_end,
  output logic        q_push,
  output q_entry_t    q_data
);

  localparam int CW = $clog2(RX_BUFFER_BYTES + 1);
  localparam logic [CW-1:0] RX_MAX = CW'(RX_BUFFER_BYTES);

  logic [15:0]   sync_seq;
  logic [15:0]   announce_seq;
  logic [CW-1:0] rx_count;
  logic [CW-1:0] rx_count_next;
  logic [7:0]    rx_first_byte;
  logic [79:0]   rx_port_identity;
  logic [15:0]   rx_sequence;
  logic          dresp_ok;

  assign rx_count_next = (rx_count < RX_MAX) ? rx_count + 1'b1 : rx_count;
  assign dresp_ok = rx_end && (rx_count_next >= CW'(44)) && (rx_first_byte[3:0] == 4'h1);

  always_comb begin
    q_push = 1'b0;
    q_data.kind = K_SYNC;
    q_data.seq = sync_seq;
    q_data.time_ns = time_ns;
    q_data.port_id = rx_port_identity;
    case (op)
      OP_SYNC: q_push = accept;
      OP_ANN: begin
        q_push = accept;
        q_data.kind = K_ANN;
        q_data.seq = announce_seq;
      end
      OP_RX: begin
        q_push = accept && dresp_ok;
        q_data.kind = K_DRESP;
        q_data.seq = rx_sequence;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_seq <= '0;
      announce_seq <= '0;
      rx_count <= '0;
      rx_first_byte <= '0;
      rx_sequence <= '0;
    end else if (accept) begin
      if (op == OP_SYNC) sync_seq <= sync_seq + 16'd1;
      if (op == OP_ANN) announce_seq <= announce_seq + 16'd1;
      if (op == OP_RX) begin
        if (rx_count < RX_MAX) begin
          if (rx_count == '0) rx_first_byte <= rx_byte;
          if (rx_count == CW'(30)) rx_sequence[15:8] <= rx_byte;
          if (rx_count == CW'(31)) rx_sequence[7:0] <= rx_byte;
        end
        rx_count <= rx_end ? '0 : rx_count_next;
      end
    end
  end

  // port identity bytes 20..29, no reset needed
  always_ff @(posedge clk) begin
    if (accept && op == OP_RX && rx_count >= CW'(20) && rx_count < CW'(30)) begin
      for (int i = 0; i < 10; i++)
        if (rx_count == CW'(20 + i)) rx_port_identity[79 - 8 * i -: 8] <= rx_byte;
    end
  end

endmodule

[rtl/core/gmf_queue.sv]
// gmf_queue: short work queue between front and back.
// Depends on gmf_pkg.
`timescale 1ns / 1ps
module gmf_queue
  import gmf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output q_entry_t rdata
);

  q_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= (QPTR_W + 1)'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

[rtl/core/gmf_back.sv]
// gmf_back: splits the timestamp into seconds/nanoseconds and emits message words.
// Depends on gmf_pkg.
`timescale 1ns / 1ps
module gmf_back
  import gmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] clock_identity,
  input  logic        q_empty,
  input  q_entry_t    q_data,
  output logic        q_pop,
  output logic [63:0] word_data,
  output logic [3:0]  word_bytes,
  output logic        packet_end,
  output logic [3:0]  msg_type,
  output logic        event_channel,
  output logic        run_last,
  output logic        empty,
  input  logic        pop
);

  back_state_t state;
  back_state_t state_next;
  q_entry_t    cur;
  msg_kind_t   msg;
  logic [3:0]  wi;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [34:0] quo;
  logic [49:0] prod;
  logic [63:0] fold;
  logic        ovalid;
  logic        slot_free;
  logic        load;
  logic [639:0] img;
  logic [3:0]  widx;
  logic [6:0]  left;
  logic        last_word;

  assign slot_free = !ovalid || pop;
  assign prod = hi * FOLD_MUL;
  assign fold = {3'b000, prod, 11'd0} + {32'd0, lo};
  assign img = build_msg(msg, clock_identity, cur.seq, {13'd0, quo}, lo, cur.port_id);
  assign widx = 4'd9 - wi;
  assign left = msg_len(msg) - {wi, 3'b000};
  assign last_word = (left <= 7'd8);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!q_empty) state_next = B_DIV;
      B_DIV:  if (fold[63:32] == 32'd0) state_next = B_FIX;
      B_FIX:  if (lo < NS_PER_S) state_next = B_EMIT;
      B_EMIT: if (slot_free && last_word && msg != M_SYNC) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
    load  = (state == B_EMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) ovalid <= 1'b1;
      else if (pop) ovalid <= 1'b0;
    end
  end

  // time = quo * 1e9 + {hi, lo}: fold the top word down (at most 11 steps),
  // then take off 1e9 until the low word is below it (at most 4 steps)
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
      hi <= q_data.time_ns[63:32];
      lo <= q_data.time_ns[31:0];
      quo <= '0;
      wi <= '0;
      case (q_data.kind)
        K_ANN:   msg <= M_ANN;
        K_DRESP: msg <= M_DR;
        default: msg <= M_SYNC;
      endcase
    end else if (state == B_DIV) begin
      hi <= fold[63:32];
      lo <= fold[31:0];
      quo <= quo + {1'b0, hi, 2'b00};
    end else if (state == B_FIX) begin
      if (lo >= NS_PER_S) begin
        lo <= lo - NS_PER_S;
        quo <= quo + 35'd1;
      end
    end else if (load) begin
      if (last_word) begin
        wi <= '0;
        msg <= M_FU;
      end else begin
        wi <= wi + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_data <= img[{widx, 6'b000000} +: 64];
      word_bytes <= last_word ? left[3:0] : 4'd8;
      packet_end <= last_word;
      msg_type <= msg_code(msg);
      event_channel <= (msg == M_SYNC);
      run_last <= last_word && (msg != M_SYNC);
    end
  end

  assign empty = !ovalid;

`ifndef NO_ASSERTIONS
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
      state == B_DIV |=> state == B_DIV || state == B_FIX)
    else $error("divider left early");
  a_bytes: assert property (@(posedge clk) disable iff (rst)
      ovalid |-> word_bytes != 4'd0 && word_bytes <= 4'd8)
    else $error("bad byte count");
  a_last: assert property (@(posedge clk) disable iff (rst)
      ovalid && run_last |-> packet_end)
    else $error("run end inside packet");
`endif

endmodule

[tb/gptp_master_message_framer_test.sv]
// Self-checking bench for gptp_master_message_framer: drives ticks and received
// datagrams, predicts every output word and checks it. Depends on gmf_pkg and the RTL.
`timescale 1ns / 1ps

class framer_scoreboard;
  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        pend;
    logic [3:0]  mtype;
    logic        ev;
    logic        last;
  } word_t;

  word_t       pending[$];
  logic [63:0] clk_id;
  logic [15:0] sync_seq, ann_seq, rx_seq;
  int unsigned rx_cnt;
  logic [7:0]  rx_first;
  logic [7:0]  rx_pid[10];
  int          errors;

  function new();
    clk_id = '0; sync_seq = '0; ann_seq = '0; rx_seq = '0;
    rx_cnt = 0; rx_first = '0; errors = 0;
    foreach (rx_pid[i]) rx_pid[i] = '0;
  endfunction

  function void put_clock(ref logic [7:0] p[80], input int at);
    for (int i = 0; i < 8; i++) p[at + i] = clk_id[63 - 8 * i -: 8];
  endfunction

  function void put_stamp(ref logic [7:0] p[80], input logic [63:0] ns);
    logic [63:0] s;
    logic [63:0] n;
    s = ns / 64'd1_000_000_000;
    n = ns % 64'd1_000_000_000;
    for (int i = 0; i < 6; i++) p[34 + i] = s[47 - 8 * i -: 8];
    for (int i = 0; i < 4; i++) p[40 + i] = n[31 - 8 * i -: 8];
  endfunction

  function void header(ref logic [7:0] p[80], input logic [3:0] t, input int len,
                       input logic [15:0] seq, input logic [15:0] flags,
                       input logic [7:0] ctl, input logic [7:0] ivl);
    foreach (p[i]) p[i] = '0;
    p[0] = {4'h1, t};
    p[1] = 8'h02;
    p[3] = len[7:0];
    p[6] = flags[15:8]; p[7] = flags[7:0];
    put_clock(p, 20);
    p[28] = 8'h80; p[29] = 8'h01;
    p[30] = seq[15:8]; p[31] = seq[7:0];
    p[32] = ctl; p[33] = ivl;
  endfunction

  function void queue_msg(ref logic [7:0] p[80], input int len, input logic [3:0] t,
                          input logic ev);
    word_t w;
    for (int pos = 0; pos < len; pos += 8) begin
      w.nbytes = 4'((len - pos < 8) ? len - pos : 8);
      w.data = '0;
      for (int i = 0; i < 8; i++) w.data = {w.data[55:0], (i < w.nbytes) ? p[pos + i] : 8'h00};
      w.pend = (pos + 8 >= len);
      w.mtype = t; w.ev = ev; w.last = 1'b0;
      pending.push_back(w);
    end
  endfunction

  // Note one accepted input beat and queue the words it produces.
  function void note_beat(logic [1:0] op, logic [63:0] ns, logic [7:0] b, logic e);
    logic [7:0] p[80];
    int prev_size;
    prev_size = pending.size();
    if (op == gmf_pkg::OP_SYNC) begin
      header(p, 4'd0, 44, sync_seq, 16'h0608, 8'd0, 8'hfd);
      queue_msg(p, 44, 4'd0, 1'b1);
      header(p, 4'd8, 76, sync_seq, 16'h0408, 8'd2, 8'hfd);
      put_stamp(p, ns);
      p[45] = 8'd3; p[47] = 8'd28; p[49] = 8'h80; p[50] = 8'hc2; p[53] = 8'h01;
      queue_msg(p, 76, 4'd8, 1'b0);
      sync_seq++;
    end else if (op == gmf_pkg::OP_ANN) begin
      header(p, 4'd11, 76, ann_seq, 16'h0408, 8'd5, 8'h00);
      ann_seq++;
      put_stamp(p, ns);
      p[45] = 8'd37; p[47] = 8'd128; p[48] = 8'd6; p[49] = 8'h21;
      p[50] = 8'h43; p[51] = 8'h6a; p[52] = 8'd128;
      put_clock(p, 53);
      p[63] = 8'h20; p[65] = 8'd8; p[67] = 8'd8;
      put_clock(p, 68);
      queue_msg(p, 76, 4'd11, 1'b0);
    end else if (op == gmf_pkg::OP_RX) begin
      if (rx_cnt < 256) begin
        if (rx_cnt == 0) rx_first = b;
        else if (rx_cnt >= 20 && rx_cnt < 30) rx_pid[rx_cnt - 20] = b;
        else if (rx_cnt == 30) rx_seq[15:8] = b;
        else if (rx_cnt == 31) rx_seq[7:0] = b;
        rx_cnt++;
      end
      if (e) begin
        if (rx_cnt >= 44 && rx_first[3:0] == 4'h1) begin
          header(p, 4'd9, 54, rx_seq, 16'h0408, 8'd3, 8'h7f);
          put_stamp(p, ns);
          for (int i = 0; i < 10; i++) p[44 + i] = rx_pid[i];
          queue_msg(p, 54, 4'd9, 1'b0);
        end
        rx_cnt = 0;
      end
    end
    if (pending.size() > prev_size) pending[pending.size() - 1].last = 1'b1;
  endfunction

  function void check_word(logic [63:0] d, logic [3:0] nb, logic pe, logic [3:0] mt,
                           logic ev, logic rl);
    word_t w;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected word %h", d);
      return;
    end
    w = pending.pop_front();
    if (d !== w.data || nb !== w.nbytes || pe !== w.pend || mt !== w.mtype ||
        ev !== w.ev || rl !== w.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch exp %h/%0d/%b/%0d/%b/%b got %h/%0d/%b/%0d/%b/%b",
                 w.data, w.nbytes, w.pend, w.mtype, w.ev, w.last, d, nb, pe, mt, ev, rl);
    end
  endfunction
endclass

module gptp_master_message_framer_test;
  import gmf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [63:0] clock_identity = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  op = OP_SYNC;
  logic [63:0] time_ns = '0;
  logic [7:0]  rx_byte = '0;
  logic        rx_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] word_data;
  logic [3:0]  word_bytes;
  logic        packet_end;
  logic [3:0]  msg_type;
  logic        event_channel;
  logic        run_last;

  framer_scoreboard sb = new();
  bit   calm = 1'b0;
  int   idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gptp_master_message_framer i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .clock_identity(clock_identity),
    .push(push), .full(full), .op(op), .time_ns(time_ns), .rx_byte(rx_byte),
    .rx_end(rx_end), .empty(empty), .pop(pop), .word_data(word_data),
    .word_bytes(word_bytes), .packet_end(packet_end), .msg_type(msg_type),
    .event_channel(event_channel), .run_last(run_last)
  );

  // Sample at the edge that accepts a beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_beat(op, time_ns, rx_byte, rx_end);
      if (pop && !empty)
        sb.check_word(word_data, word_bytes, packet_end, msg_type, event_channel, run_last);
      if ((push && !full) || (pop && !empty) || (!push && sb.pending.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("gptp_master_message_framer_test: FAIL");
        $finish;
      end
    end
  end

  // Receiver side: random stall bursts until the calm tail.
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else if (!calm && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      repeat ($urandom_range(1, 3) - 1) @(posedge clk);
    end else pop <= 1'b1;
  end

  task automatic send(logic [1:0] o, logic [63:0] ns, logic [7:0] b, logic e);
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push <= 1'b1; op <= o; time_ns <= ns; rx_byte <= b; rx_end <= e;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_id(logic [63:0] v);
    cfg_we <= 1'b1; clock_identity <= v;
    @(posedge clk);
    sb.clk_id = v;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_ns();
    case ($urandom_range(0, 3))
      0: rand_ns = '1;
      1: rand_ns = '0;
      2: rand_ns = {32'd0, $urandom};
      default: rand_ns = {$urandom, $urandom};
    endcase
  endfunction

  // Datagram: len bytes; delay_req selects a valid low nibble.
  task automatic send_dgram(int len, bit delay_req, logic [63:0] ns);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 0) b = delay_req ? {b[7:4], 4'h1} : {b[7:4], 4'h2 + b[1:0]};
      send(OP_RX, (i == len - 1) ? ns : rand_ns(), b, i == len - 1);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_id(64'h0123_4567_89ab_cdef);

    // Directed: each op, time extremes, a Delay_Req, short and wrong datagrams, op 3.
    send(OP_SYNC, '0, 8'h00, 1'b0);
    send(OP_SYNC, '1, 8'hff, 1'b1);
    send(OP_ANN, '0, 8'h00, 1'b0);
    send(OP_ANN, '1, 8'hff, 1'b1);
    send(OP_RSVD, '1, 8'hff, 1'b1);
    send_dgram(44, 1, '1);
    send_dgram(43, 1, '0);
    send_dgram(45, 0, 64'd999_999_999);
    send(OP_SYNC, 64'd1_000_000_000, 8'h00, 1'b0);
    send_dgram(3, 1, '1);
    wait_idle();
    write_id('1);

    for (int n = 0; n < 60; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send(OP_SYNC, rand_ns(), 8'($urandom), 1'($urandom));
        4, 5, 6: send(OP_ANN, rand_ns(), 8'($urandom), 1'($urandom));
        7: send(OP_RSVD, rand_ns(), 8'($urandom), 1'($urandom));
        default: send_dgram($urandom_range(1, 4), 1'($urandom), rand_ns());
      endcase
      if (n == 20) begin
        wait_idle();
        write_id('0);
      end
      if (n == 40) begin
        wait_idle();
        write_id({$urandom, $urandom});
        calm = 1'b1;
      end
    end
    wait_idle();
    if (sb.errors == 0) $display("gptp_master_message_framer_test: PASS");
    else $display("gptp_master_message_framer_test: FAIL");
    $finish;
  end
endmodule

[files.f]
rtl/core/gmf_pkg.sv
rtl/core/gmf_front.sv
rtl/core/gmf_queue.sv
rtl/core/gmf_back.sv
rtl/core/gptp_master_message_framer.sv
tb/gptp_master_message_framer_test.sv
